FILE: rtl/assert_macros.svh
// Assertion helpers for the checker module of this block.
// Both sample on the rising edge of clk_i and are held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPVS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpvs check failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define MPVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpvs check failed: next-cycle property");

`endif

FILE: rtl/mpvs_pkg.sv
// ----------------------------------------------------------------------------
// mpvs_pkg
// Shared constants, codes and types of the MessagePack value skipper.
// ----------------------------------------------------------------------------
`default_nettype none

package mpvs_pkg;

  localparam int MaxDepth   = 32;
  localparam int MaxItems   = 256;

  localparam int LevelW     = $clog2(MaxDepth + 1);
  localparam int IdxW       = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int CountW     = $clog2(MaxItems + 1);
  localparam int ItemsSeenW = 9;
  localparam int AccW       = 32;
  localparam int PayW       = 33;
  localparam int HdrW       = 3;

  // Type byte codes and masks.
  localparam logic [7:0] PosFixMax   = 8'h7f;
  localparam logic [7:0] NegFixMin   = 8'he0;
  localparam logic [7:0] MaskFixStr  = 8'he0;
  localparam logic [7:0] MaskFixCont = 8'hf0;
  localparam logic [7:0] FixStrBase  = 8'ha0;
  localparam logic [7:0] FixArrBase  = 8'h90;
  localparam logic [7:0] FixMapBase  = 8'h80;
  localparam logic [7:0] CodeNil     = 8'hc0;
  localparam logic [7:0] CodeFalse   = 8'hc2;
  localparam logic [7:0] CodeTrue    = 8'hc3;
  localparam logic [7:0] CodeBin8    = 8'hc4;
  localparam logic [7:0] CodeBin16   = 8'hc5;
  localparam logic [7:0] CodeBin32   = 8'hc6;
  localparam logic [7:0] CodeExt8    = 8'hc7;
  localparam logic [7:0] CodeExt16   = 8'hc8;
  localparam logic [7:0] CodeExt32   = 8'hc9;
  localparam logic [7:0] CodeFloat32 = 8'hca;
  localparam logic [7:0] CodeFloat64 = 8'hcb;
  localparam logic [7:0] CodeUint8   = 8'hcc;
  localparam logic [7:0] CodeUint16  = 8'hcd;
  localparam logic [7:0] CodeUint32  = 8'hce;
  localparam logic [7:0] CodeUint64  = 8'hcf;
  localparam logic [7:0] CodeInt8    = 8'hd0;
  localparam logic [7:0] CodeInt16   = 8'hd1;
  localparam logic [7:0] CodeInt32   = 8'hd2;
  localparam logic [7:0] CodeInt64   = 8'hd3;
  localparam logic [7:0] CodeFixExt1 = 8'hd4;
  localparam logic [7:0] CodeFixExt2 = 8'hd5;
  localparam logic [7:0] CodeFixExt4 = 8'hd6;
  localparam logic [7:0] CodeFixExt8 = 8'hd7;
  localparam logic [7:0] CodeFixExt16 = 8'hd8;
  localparam logic [7:0] CodeStr8    = 8'hd9;
  localparam logic [7:0] CodeStr16   = 8'hda;
  localparam logic [7:0] CodeStr32   = 8'hdb;
  localparam logic [7:0] CodeArray16 = 8'hdc;
  localparam logic [7:0] CodeArray32 = 8'hdd;
  localparam logic [7:0] CodeMap16   = 8'hde;
  localparam logic [7:0] CodeMap32   = 8'hdf;

  typedef enum logic [1:0] {
    StatusOpen    = 2'd0,
    StatusDone    = 2'd1,
    StatusFail    = 2'd2,
    StatusIgnored = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CauseNone       = 3'd0,
    CauseReserved   = 3'd1,
    CauseTruncated  = 3'd2,
    CauseDepth      = 3'd3,
    CauseItemLimit  = 3'd4,
    CauseCountLarge = 3'd5
  } cause_e;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic              pop;
    logic [CountW-1:0] count;
  } stack_op_t;

  typedef struct packed {
    logic full;     // no room for another level
    logic unwinds;  // a pop now would close every open container
  } stack_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mpvs_stack.sv
// ----------------------------------------------------------------------------
// mpvs_stack
// Stack of remaining child counts, one entry per open container, with one
// pop unwinding every container that the finished value completes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpvs_stack (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mpvs_pkg::stack_op_t  op_i,
  output mpvs_pkg::stack_stat_t     stat_o
);

  logic [mpvs_pkg::LevelW-1:0] level_q;
  logic [mpvs_pkg::CountW-1:0] entry_q [mpvs_pkg::MaxDepth];
  logic                        one_q   [mpvs_pkg::MaxDepth];

  logic                        hit;
  logic [mpvs_pkg::IdxW-1:0]   hit_idx;
  logic [mpvs_pkg::CountW-1:0] top_val;

  // The deepest open level whose count is not one survives the pop; every
  // level above it closes along with the value.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < mpvs_pkg::MaxDepth; i++) begin
      if ((mpvs_pkg::LevelW'(i) < level_q) && !one_q[i]) begin
        hit     = 1'b1;
        hit_idx = mpvs_pkg::IdxW'(i);
      end
    end
    top_val        = entry_q[hit_idx];
    stat_o.full    = (level_q == mpvs_pkg::LevelW'(mpvs_pkg::MaxDepth));
    stat_o.unwinds = !hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (op_i.clear) begin
      level_q <= '0;
    end else if (op_i.push) begin
      level_q <= level_q + mpvs_pkg::LevelW'(1);
    end else if (op_i.pop) begin
      level_q <= hit ? (mpvs_pkg::LevelW'(hit_idx) + mpvs_pkg::LevelW'(1)) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      entry_q[level_q[mpvs_pkg::IdxW-1:0]] <= op_i.count;
      one_q[level_q[mpvs_pkg::IdxW-1:0]]   <= (op_i.count == mpvs_pkg::CountW'(1));
    end else if (op_i.pop && hit) begin
      entry_q[hit_idx] <= top_val - mpvs_pkg::CountW'(1);
      one_q[hit_idx]   <= (top_val == mpvs_pkg::CountW'(2));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msgpack_value_skipper_top.sv
// A byte accepted into the input register has its result registered in the
// result register. Throughput: one byte per cycle while the result is not
// stalled, set by the single pass from input register through the decode,
// header, payload and stack logic into the result register.
// Reset clears all control state at once; stack contents are left as they are.
// ----------------------------------------------------------------------------
// msgpack_value_skipper_top
// Checks that a MessagePack frame, one byte per word, starts with one
// well-formed value, and reports per byte whether the value is open, done,
// failed or already past.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_value_skipper_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       frame_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic [2:0]      fail_cause_o,
  output logic [8:0]      items_seen_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Frame state.
  logic                          done_q,     done_d;
  logic [mpvs_pkg::CountW-1:0]   items_q,    items_d;
  logic [7:0]                    hdr_code_q, hdr_code_d;
  logic [mpvs_pkg::HdrW-1:0]     hdr_left_q, hdr_left_d;
  logic [mpvs_pkg::AccW-1:0]     acc_q,      acc_d;
  logic [mpvs_pkg::PayW-1:0]     pay_q,      pay_d;

  // Result register.
  logic                              out_valid_q;
  mpvs_pkg::status_e                 status_q,  status_d;
  mpvs_pkg::cause_e                  cause_q,   cause_d;
  logic [mpvs_pkg::ItemsSeenW-1:0]   seen_q;

  logic advance;
  logic accept;
  logic proc;

  mpvs_pkg::stack_op_t   stk_op;
  mpvs_pkg::stack_stat_t stk_stat;

  logic [mpvs_pkg::AccW-1:0] acc_shift;
  logic [mpvs_pkg::HdrW-1:0] hdr_left_dec;
  logic [mpvs_pkg::PayW-1:0] pay_dec;
  logic                      pay_go;
  logic [mpvs_pkg::PayW-1:0] pay_len;
  logic                      open_go;
  logic [mpvs_pkg::PayW-1:0] open_len;
  logic                      done_go;
  logic                      fail_go;
  mpvs_pkg::cause_e          fail_cause;
  logic                      hdr_go;
  logic [mpvs_pkg::HdrW-1:0] hdr_n;
  logic                      push;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign proc       = in_valid_q && advance;

  always_comb begin
    acc_shift    = {acc_q[mpvs_pkg::AccW-9:0], in_byte_q};
    hdr_left_dec = hdr_left_q - mpvs_pkg::HdrW'(1);
    pay_dec      = pay_q - mpvs_pkg::PayW'(1);
    pay_go       = 1'b0;
    pay_len      = '0;
    open_go      = 1'b0;
    open_len     = '0;
    done_go      = 1'b0;
    fail_go      = 1'b0;
    fail_cause   = mpvs_pkg::CauseNone;
    hdr_go       = 1'b0;
    hdr_n        = '0;
    push         = 1'b0;
    status_d     = mpvs_pkg::StatusOpen;
    cause_d      = mpvs_pkg::CauseNone;
    done_d       = done_q;
    items_d      = items_q;
    hdr_code_d   = hdr_code_q;
    hdr_left_d   = hdr_left_q;
    acc_d        = acc_q;
    pay_d        = pay_q;

    if (done_q) begin
      status_d = mpvs_pkg::StatusIgnored;
    end else begin
      if (hdr_left_q != '0) begin
        acc_d      = acc_shift;
        hdr_left_d = hdr_left_dec;
        if (hdr_left_dec == '0) begin
          case (hdr_code_q)
            mpvs_pkg::CodeBin8, mpvs_pkg::CodeBin16, mpvs_pkg::CodeBin32,
            mpvs_pkg::CodeStr8, mpvs_pkg::CodeStr16, mpvs_pkg::CodeStr32: begin
              pay_go  = 1'b1;
              pay_len = {1'b0, acc_shift};
            end
            // The extension type byte counts as part of the payload.
            mpvs_pkg::CodeExt8, mpvs_pkg::CodeExt16, mpvs_pkg::CodeExt32: begin
              pay_go  = 1'b1;
              pay_len = {1'b0, acc_shift} + mpvs_pkg::PayW'(1);
            end
            mpvs_pkg::CodeArray16, mpvs_pkg::CodeArray32: begin
              open_go  = 1'b1;
              open_len = {1'b0, acc_shift};
            end
            default: begin
              open_go  = 1'b1;
              open_len = {acc_shift, 1'b0};
            end
          endcase
        end
      end else if (pay_q != '0) begin
        pay_d = pay_dec;
        if (pay_dec == '0) begin
          done_go = 1'b1;
        end
      end else if (items_q >= mpvs_pkg::CountW'(mpvs_pkg::MaxItems)) begin
        fail_go    = 1'b1;
        fail_cause = mpvs_pkg::CauseItemLimit;
      end else begin
        items_d = items_q + mpvs_pkg::CountW'(1);
        if ((in_byte_q <= mpvs_pkg::PosFixMax) || (in_byte_q >= mpvs_pkg::NegFixMin) ||
            (in_byte_q == mpvs_pkg::CodeNil) || (in_byte_q == mpvs_pkg::CodeFalse) ||
            (in_byte_q == mpvs_pkg::CodeTrue)) begin
          done_go = 1'b1;
        end else if ((in_byte_q & mpvs_pkg::MaskFixStr) == mpvs_pkg::FixStrBase) begin
          pay_go  = 1'b1;
          pay_len = mpvs_pkg::PayW'(in_byte_q[4:0]);
        end else if ((in_byte_q & mpvs_pkg::MaskFixCont) == mpvs_pkg::FixArrBase) begin
          open_go  = 1'b1;
          open_len = mpvs_pkg::PayW'(in_byte_q[3:0]);
        end else if ((in_byte_q & mpvs_pkg::MaskFixCont) == mpvs_pkg::FixMapBase) begin
          open_go  = 1'b1;
          open_len = mpvs_pkg::PayW'({in_byte_q[3:0], 1'b0});
        end else begin
          case (in_byte_q)
            mpvs_pkg::CodeBin8, mpvs_pkg::CodeStr8, mpvs_pkg::CodeExt8: begin
              hdr_go = 1'b1;
              hdr_n  = mpvs_pkg::HdrW'(1);
            end
            mpvs_pkg::CodeBin16, mpvs_pkg::CodeStr16, mpvs_pkg::CodeExt16,
            mpvs_pkg::CodeArray16, mpvs_pkg::CodeMap16: begin
              hdr_go = 1'b1;
              hdr_n  = mpvs_pkg::HdrW'(2);
            end
            mpvs_pkg::CodeBin32, mpvs_pkg::CodeStr32, mpvs_pkg::CodeExt32,
            mpvs_pkg::CodeArray32, mpvs_pkg::CodeMap32: begin
              hdr_go = 1'b1;
              hdr_n  = mpvs_pkg::HdrW'(4);
            end
            mpvs_pkg::CodeFloat32: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(4);
            end
            mpvs_pkg::CodeFloat64: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(8);
            end
            mpvs_pkg::CodeUint8, mpvs_pkg::CodeInt8: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(1);
            end
            mpvs_pkg::CodeUint16, mpvs_pkg::CodeInt16, mpvs_pkg::CodeFixExt1: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(2);
            end
            mpvs_pkg::CodeUint32, mpvs_pkg::CodeInt32: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(4);
            end
            mpvs_pkg::CodeUint64, mpvs_pkg::CodeInt64: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(8);
            end
            mpvs_pkg::CodeFixExt2: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(3);
            end
            mpvs_pkg::CodeFixExt4: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(5);
            end
            mpvs_pkg::CodeFixExt8: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(9);
            end
            mpvs_pkg::CodeFixExt16: begin
              pay_go  = 1'b1;
              pay_len = mpvs_pkg::PayW'(17);
            end
            default: begin
              fail_go    = 1'b1;
              fail_cause = mpvs_pkg::CauseReserved;
            end
          endcase
        end
      end

      if (hdr_go) begin
        hdr_code_d = in_byte_q;
        hdr_left_d = hdr_n;
        acc_d      = '0;
      end

      if (pay_go) begin
        pay_d = pay_len;
        if (pay_len == '0) begin
          done_go = 1'b1;
        end
      end

      if (open_go) begin
        if (open_len > mpvs_pkg::PayW'(mpvs_pkg::MaxItems)) begin
          fail_go    = 1'b1;
          fail_cause = mpvs_pkg::CauseCountLarge;
        end else if (open_len == '0) begin
          done_go = 1'b1;
        end else if (stk_stat.full) begin
          fail_go    = 1'b1;
          fail_cause = mpvs_pkg::CauseDepth;
        end else begin
          push = 1'b1;
        end
      end

      if (done_go && stk_stat.unwinds) begin
        status_d = mpvs_pkg::StatusDone;
      end
      if (fail_go) begin
        status_d = mpvs_pkg::StatusFail;
        cause_d  = fail_cause;
      end
      if ((status_d == mpvs_pkg::StatusOpen) && in_last_q) begin
        status_d = mpvs_pkg::StatusFail;
        cause_d  = mpvs_pkg::CauseTruncated;
      end
      if ((status_d == mpvs_pkg::StatusDone) || (status_d == mpvs_pkg::StatusFail)) begin
        done_d = 1'b1;
      end
    end

    stk_op.clear = proc && in_last_q;
    stk_op.push  = proc && push;
    stk_op.pop   = proc && done_go;
    stk_op.count = open_len[mpvs_pkg::CountW-1:0];
  end

  mpvs_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (stk_op),
    .stat_o (stk_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      items_q     <= '0;
      hdr_code_q  <= '0;
      hdr_left_q  <= '0;
      acc_q       <= '0;
      pay_q       <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (proc) begin
        // The frame's last byte returns the block to its reset state.
        if (in_last_q) begin
          done_q     <= 1'b0;
          items_q    <= '0;
          hdr_code_q <= '0;
          hdr_left_q <= '0;
          acc_q      <= '0;
          pay_q      <= '0;
        end else begin
          done_q     <= done_d;
          items_q    <= items_d;
          hdr_code_q <= hdr_code_d;
          hdr_left_q <= hdr_left_d;
          acc_q      <= acc_d;
          pay_q      <= pay_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= byte_value_i;
      in_last_q <= frame_last_i;
    end
    if (proc) begin
      status_q <= status_d;
      cause_q  <= cause_d;
      seen_q   <= mpvs_pkg::ItemsSeenW'(items_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign fail_cause_o = cause_q;
  assign items_seen_o = seen_q;

endmodule

`default_nettype wire

FILE: rtl/mpvs_checker.sv
// ----------------------------------------------------------------------------
// mpvs_checker
// Port-level checks on the result stream of the value skipper.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mpvs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] byte_value_i,
  input wire logic       frame_last_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic [2:0] fail_cause_o,
  input wire logic [8:0] items_seen_o
);

  logic in_word;
  assign in_word = in_valid_i && !in_stall_o && (frame_last_i || (byte_value_i != 8'h00));

  // A cause is reported only with a failure, and only the known causes appear.
  `MPVS_ASSERT_IMPL(a_cause_needs_fail, out_valid_o && (fail_cause_o != 3'(mpvs_pkg::CauseNone)), status_o == 2'(mpvs_pkg::StatusFail))
  `MPVS_ASSERT_IMPL(a_cause_range, out_valid_o, fail_cause_o <= 3'(mpvs_pkg::CauseCountLarge))

  // The item limit trips only once the counter has reached the limit.
  `MPVS_ASSERT_IMPL(a_limit_count, out_valid_o && (fail_cause_o == 3'(mpvs_pkg::CauseItemLimit)), items_seen_o == mpvs_pkg::ItemsSeenW'(mpvs_pkg::MaxItems))

  // A stalled result word holds its contents.
  `MPVS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i && !in_word, out_valid_o && $stable(status_o) && $stable(fail_cause_o) && $stable(items_seen_o))

endmodule

bind msgpack_value_skipper_top mpvs_checker u_mpvs_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives MessagePack frames, one byte per word, into the value skipper and
// checks every result word against a cycle-free model of the byte walker.
// Directed frames hit the edge cases, then random frames run under four
// idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpvs_pkg::*;

  localparam logic [7:0] CodeReserved = 8'hc1;

  localparam logic [7:0] NumCodes [10] = '{CodeFloat32, CodeFloat64, CodeUint8, CodeUint16,
      CodeUint32, CodeUint64, CodeInt8, CodeInt16, CodeInt32, CodeInt64};
  localparam int NumSizes [10] = '{4, 8, 1, 2, 4, 8, 1, 2, 4, 8};
  localparam logic [7:0] FixExtCodes [5] = '{CodeFixExt1, CodeFixExt2, CodeFixExt4,
      CodeFixExt8, CodeFixExt16};
  localparam int FixExtSizes [5] = '{2, 3, 5, 9, 17};
  localparam logic [7:0] WideLenCodes [6] = '{CodeBin16, CodeStr16, CodeExt16, CodeBin32,
      CodeStr32, CodeExt32};

  localparam int SendIdlePct [4] = '{0, 79, 0, 25};
  localparam int RecvStallPct [4] = '{0, 0, 79, 25};

  typedef enum logic [1:0] {
    PhaseAwait = 2'd0,
    PhaseOpen  = 2'd1,
    PhaseDone  = 2'd2
  } frame_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    status_e    status;
    cause_e     cause;
    logic [8:0] items;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] byte_value_i = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [2:0] fail_cause_o;
  logic [8:0] items_seen_o;

  byte_word_t byte_feed_q[$];
  verdict_t   pending_verdicts_q[$];
  logic [7:0] frame_bytes[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int frame_count = 0;
  int queued_bytes = 0;
  int seen_done = 0;
  int seen_fail = 0;
  int seen_ignored = 0;
  int seen_words = 0;

  // Walker state, mirrored from the block.
  logic [8:0]        walk_children [MaxDepth];
  logic [LevelW-1:0] walk_level;
  logic [CountW-1:0] walk_items;
  logic [7:0]        walk_hdr_code;
  logic [2:0]        walk_hdr_left;
  logic [31:0]       walk_hdr_acc;
  logic [32:0]       walk_payload_left;
  frame_phase_e      walk_phase;
  status_e           walk_status;
  cause_e            walk_cause;

  msgpack_value_skipper_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_value_i(byte_value_i),
    .frame_last_i(frame_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .fail_cause_o(fail_cause_o),
    .items_seen_o(items_seen_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------- walker model ----------------

  function automatic void clear_walker();
    walk_level = '0;
    walk_items = '0;
    walk_hdr_code = '0;
    walk_hdr_left = '0;
    walk_hdr_acc = '0;
    walk_payload_left = '0;
    walk_phase = PhaseAwait;
  endfunction

  function automatic void fail_value(cause_e c);
    walk_status = StatusFail;
    walk_cause = c;
  endfunction

  // A value just ended: pop every container whose last child this was.
  function automatic void close_value();
    while (1'b1) begin
      if (walk_level == 0) begin
        walk_status = StatusDone;
        return;
      end
      walk_children[walk_level - 1] = walk_children[walk_level - 1] - 9'd1;
      if (walk_children[walk_level - 1] != 0) return;
      walk_level = walk_level - 1'b1;
    end
  endfunction

  function automatic void start_payload(logic [32:0] n);
    walk_payload_left = n;
    if (n == 0) close_value();
  endfunction

  function automatic void open_container(logic [33:0] n);
    if (n > MaxItems) begin
      fail_value(CauseCountLarge);
    end else if (n == 0) begin
      close_value();
    end else if (walk_level + 1 > MaxDepth) begin
      fail_value(CauseDepth);
    end else begin
      walk_children[walk_level] = n[8:0];
      walk_level = walk_level + 1'b1;
    end
  endfunction

  function automatic void open_header(logic [7:0] code, logic [2:0] nbytes);
    walk_hdr_code = code;
    walk_hdr_left = nbytes;
    walk_hdr_acc = '0;
  endfunction

  function automatic void finish_header();
    case (walk_hdr_code)
      CodeBin8, CodeBin16, CodeBin32, CodeStr8, CodeStr16, CodeStr32: begin
        start_payload({1'b0, walk_hdr_acc});
      end
      CodeExt8, CodeExt16, CodeExt32: begin
        start_payload({1'b0, walk_hdr_acc} + 33'd1);
      end
      CodeArray16, CodeArray32: begin
        open_container({2'b00, walk_hdr_acc});
      end
      default: begin
        open_container({1'b0, walk_hdr_acc, 1'b0});
      end
    endcase
  endfunction

  function automatic void type_byte(logic [7:0] code);
    if (walk_items >= MaxItems) begin
      fail_value(CauseItemLimit);
      return;
    end
    walk_items = walk_items + 1'b1;
    if (code <= PosFixMax || code >= NegFixMin || code == CodeNil ||
        code == CodeFalse || code == CodeTrue) begin
      close_value();
    end else if ((code & MaskFixStr) == FixStrBase) begin
      start_payload({28'd0, code[4:0]});
    end else if ((code & MaskFixCont) == FixArrBase) begin
      open_container({30'd0, code[3:0]});
    end else if ((code & MaskFixCont) == FixMapBase) begin
      open_container({29'd0, code[3:0], 1'b0});
    end else begin
      case (code)
        CodeBin8, CodeStr8, CodeExt8: open_header(code, 3'd1);
        CodeBin16, CodeStr16, CodeExt16, CodeArray16, CodeMap16: open_header(code, 3'd2);
        CodeBin32, CodeStr32, CodeExt32, CodeArray32, CodeMap32: open_header(code, 3'd4);
        CodeFloat32: start_payload(33'd4);
        CodeFloat64: start_payload(33'd8);
        CodeUint8, CodeInt8: start_payload(33'd1);
        CodeUint16, CodeInt16: start_payload(33'd2);
        CodeUint32, CodeInt32: start_payload(33'd4);
        CodeUint64, CodeInt64: start_payload(33'd8);
        CodeFixExt1: start_payload(33'd2);
        CodeFixExt2: start_payload(33'd3);
        CodeFixExt4: start_payload(33'd5);
        CodeFixExt8: start_payload(33'd9);
        CodeFixExt16: start_payload(33'd17);
        default: fail_value(CauseReserved);
      endcase
    end
  endfunction

  function automatic verdict_t judge_byte(logic [7:0] b, logic last);
    verdict_t v;
    walk_status = StatusOpen;
    walk_cause = CauseNone;
    if (walk_phase == PhaseDone) begin
      walk_status = StatusIgnored;
    end else begin
      walk_phase = PhaseOpen;
      if (walk_hdr_left != 0) begin
        walk_hdr_acc = {walk_hdr_acc[23:0], b};
        walk_hdr_left = walk_hdr_left - 3'd1;
        if (walk_hdr_left == 0) finish_header();
      end else if (walk_payload_left != 0) begin
        walk_payload_left = walk_payload_left - 33'd1;
        if (walk_payload_left == 0) close_value();
      end else begin
        type_byte(b);
      end
      if (walk_status == StatusOpen && last) fail_value(CauseTruncated);
    end
    v.status = walk_status;
    v.cause = walk_cause;
    v.items = walk_items;
    if (last) begin
      clear_walker();
    end else if (walk_status == StatusDone || walk_status == StatusFail) begin
      walk_phase = PhaseDone;
    end
    return v;
  endfunction

  // ---------------- frame building ----------------

  function automatic void put_byte(logic [7:0] b);
    frame_bytes.push_back(b);
  endfunction

  function automatic void put_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void ship_frame();
    byte_word_t w;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      w.data = frame_bytes[i];
      w.last = (i == frame_bytes.size() - 1);
      byte_feed_q.push_back(w);
    end
    queued_bytes += frame_bytes.size();
    frame_bytes.delete();
    frame_count++;
  endfunction

  // Emits one well-formed value in pre-order; owed counts values still due.
  function automatic void add_value_tree();
    int owed;
    int made;
    int n;
    int sel;
    int top_kind;
    logic [7:0] code;
    owed = 1;
    made = 0;
    while (owed > 0) begin
      owed--;
      made++;
      top_kind = (made == 1) ? 12 : (made <= 10) ? 11 : 7;
      case ($urandom_range(0, top_kind))
        0: put_byte(8'($urandom_range(0, 127)));
        1: put_byte(8'($urandom_range(224, 255)));
        2: begin
          sel = $urandom_range(0, 2);
          put_byte(sel == 0 ? CodeNil : sel == 1 ? CodeFalse : CodeTrue);
        end
        3: begin
          n = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 6);
          put_byte(FixStrBase | 8'(n));
          put_random(n);
        end
        4: begin
          sel = $urandom_range(0, 2);
          code = sel == 0 ? CodeBin8 : sel == 1 ? CodeStr8 : CodeExt8;
          n = $urandom_range(0, 5);
          put_byte(code);
          put_byte(8'(n));
          put_random(code == CodeExt8 ? n + 1 : n);
        end
        5: begin
          sel = $urandom_range(0, 5);
          code = WideLenCodes[sel];
          n = $urandom_range(0, 4);
          put_byte(code);
          put_be(32'(n), sel < 3 ? 2 : 4);
          put_random((code == CodeExt16 || code == CodeExt32) ? n + 1 : n);
        end
        6: begin
          sel = $urandom_range(0, 9);
          put_byte(NumCodes[sel]);
          put_random(NumSizes[sel]);
        end
        7: begin
          sel = $urandom_range(0, 4);
          put_byte(FixExtCodes[sel]);
          put_random(FixExtSizes[sel]);
        end
        8: begin
          n = $urandom_range(0, 3);
          put_byte(FixArrBase | 8'(n));
          owed += n;
        end
        9: begin
          n = $urandom_range(0, 2);
          put_byte(FixMapBase | 8'(n));
          owed += 2 * n;
        end
        10: begin
          code = $urandom_range(0, 1) ? CodeArray16 : CodeArray32;
          n = $urandom_range(0, 3);
          put_byte(code);
          put_be(32'(n), code == CodeArray16 ? 2 : 4);
          owed += n;
        end
        11: begin
          code = $urandom_range(0, 1) ? CodeMap16 : CodeMap32;
          n = $urandom_range(0, 2);
          put_byte(code);
          put_be(32'(n), code == CodeMap16 ? 2 : 4);
          owed += 2 * n;
        end
        default: begin
          n = $urandom_range(4, 15);
          put_byte(FixArrBase | 8'(n));
          owed += n;
        end
      endcase
    end
  endfunction

  function automatic void random_frame();
    int r;
    int sel;
    int pos;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      add_value_tree();
      if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 3));
    end else if (r < 70) begin
      add_value_tree();
      if (frame_bytes.size() > 1) begin
        pos = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
      end
    end else if (r < 78) begin
      // Single-child chains around the nesting limit.
      repeat ($urandom_range(MaxDepth - 2, MaxDepth + 2)) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          put_byte(FixArrBase | 8'd1);
        end else begin
          put_byte(sel == 1 ? CodeArray16 : CodeArray32);
          put_be(32'd1, sel == 1 ? 2 : 4);
        end
      end
      add_value_tree();
    end else if (r < 86) begin
      add_value_tree();
      pos = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[pos] = $urandom_range(0, 1) ? CodeReserved : 8'($urandom_range(0, 255));
    end else if (r < 92) begin
      sel = $urandom_range(0, 3);
      code = sel == 0 ? CodeArray16 : sel == 1 ? CodeArray32 : sel == 2 ? CodeMap16 : CodeMap32;
      put_byte(code);
      put_be($urandom, (code == CodeArray16 || code == CodeMap16) ? 2 : 4);
      put_random($urandom_range(1, 3));
    end else begin
      put_random($urandom_range(1, 8));
    end
    ship_frame();
  endfunction

  // ---------------- driver and monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin : feed_proc
    byte_word_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_verdicts_q.push_back(judge_byte(byte_value_i, frame_last_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (byte_feed_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          nxt = byte_feed_q.pop_front();
          in_valid_i <= 1'b1;
          byte_value_i <= nxt.data;
          frame_last_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    verdict_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_words++;
        if (pending_verdicts_q.size() == 0) begin
          $error("result word with nothing expected: status %0d", status_o);
          err_count++;
        end else begin
          want = pending_verdicts_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_count++;
          end
          if (fail_cause_o !== want.cause) begin
            $error("fail_cause: expected %0d, got %0d", want.cause, fail_cause_o);
            err_count++;
          end
          if (items_seen_o !== want.items) begin
            $error("items_seen: expected %0d, got %0d", want.items, items_seen_o);
            err_count++;
          end
        end
        case (status_o)
          StatusDone: seen_done++;
          StatusFail: seen_fail++;
          StatusIgnored: seen_ignored++;
          default: ;
        endcase
      end
      out_stall_i <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Sampled on the falling edge so the driver's updates have settled.
  task automatic wait_all_results();
    while (byte_feed_q.size() != 0 || in_valid_i || pending_verdicts_q.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------- stimulus ----------------

  initial begin : stimulus
    int mark;
    clear_walker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-byte scalars at the edges of each range.
    put_byte(8'h00); ship_frame();
    put_byte(PosFixMax); ship_frame();
    put_byte(NegFixMin); ship_frame();
    put_byte(8'hff); ship_frame();
    put_byte(CodeNil); ship_frame();
    put_byte(CodeFalse); ship_frame();
    put_byte(CodeTrue); ship_frame();
    // Reserved code, with a following word that must be ignored.
    put_byte(CodeReserved); put_byte(8'h00); ship_frame();
    // Empty containers and zero-length payloads end on their header, but for the ext, whose type byte follows.
    put_byte(FixArrBase); ship_frame();
    put_byte(FixMapBase); ship_frame();
    put_byte(FixStrBase); ship_frame();
    put_byte(CodeArray16); put_be(32'd0, 2); ship_frame();
    put_byte(CodeMap32); put_be(32'd0, 4); ship_frame();
    put_byte(CodeStr8); put_byte(8'h00); ship_frame();
    put_byte(CodeExt8); put_byte(8'h00); put_byte(8'h05); ship_frame();
    // Frame ends inside a number.
    put_byte(CodeUint16); put_byte(8'h12); ship_frame();
    // Nesting exactly at the limit, then one level past it on the last word.
    repeat (MaxDepth) put_byte(FixArrBase | 8'd1);
    put_byte(CodeNil); ship_frame();
    repeat (MaxDepth + 1) put_byte(FixArrBase | 8'd1);
    ship_frame();
    // Counts just over the limit.
    put_byte(CodeArray16); put_be(MaxItems + 1, 2); ship_frame();
    put_byte(CodeMap32); put_be(MaxItems / 2 + 1, 4); ship_frame();
    // Largest legal count; the last child hits the value limit.
    put_byte(CodeArray16); put_be(MaxItems, 2);
    repeat (MaxItems) put_byte(CodeNil);
    put_byte(8'h01); ship_frame();
    // Maximum lengths (the 32-bit ones cut short), trailing bytes and a truncated map.
    put_byte(CodeBin32); put_be(32'hffff_ffff, 4); put_byte(8'h00); ship_frame();
    put_byte(CodeExt32); put_be(32'hffff_ffff, 4); ship_frame();
    put_byte(CodeFixExt16); put_random(17); ship_frame();
    put_byte(FixStrBase | 8'd31); put_random(31); ship_frame();
    put_byte(8'h01); put_byte(8'h02); put_byte(8'h03); ship_frame();
    put_byte(FixMapBase | 8'd1); put_byte(FixArrBase | 8'd1); ship_frame();
    wait_all_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SendIdlePct[p];
      recv_stall_pct = RecvStallPct[p];
      mark = queued_bytes;
      while (queued_bytes < mark + 20) random_frame();
      wait_all_results();
    end
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);

    $display("Checked %0d result words over %0d frames and %0d bytes.",
             seen_words, frame_count, queued_bytes);
    $display("Values finished: %0d, failed: %0d, bytes past the value: %0d.",
             seen_done, seen_fail, seen_ignored);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $error("run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: msgpack_value_skipper_top.f
+incdir+rtl
rtl/mpvs_pkg.sv
rtl/mpvs_stack.sv
rtl/msgpack_value_skipper_top.sv
rtl/mpvs_checker.sv
dv/testbench.sv
